// ===== src/mct_pkg.sv =====
// Shared constants, item codes and the per-timer request struct for the compare timer bank.
`default_nettype none
package mct_pkg;

  // Bank size and counter width
  localparam int unsigned NUM_TIMERS  = 6;
  localparam int unsigned COUNT_WIDTH = 32;
  localparam int unsigned DATA_WIDTH  = 32;
  localparam int unsigned ADDR_WIDTH  = 8;
  localparam int unsigned DIV_WIDTH   = 4;
  localparam int unsigned BLK_WIDTH   = 4;

  // Item kinds
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // Word offsets inside a register block (addr[3:2])
  localparam logic [1:0] OFF_CTRL  = 2'd0;
  localparam logic [1:0] OFF_CLK   = 2'd1;
  localparam logic [1:0] OFF_COUNT = 2'd2;
  localparam logic [1:0] OFF_CMP   = 2'd3;

  // Global block offsets
  localparam logic [1:0] OFF_IRQ_EN  = 2'd0;
  localparam logic [1:0] OFF_PENDING = 2'd2;

  // Operating modes
  localparam logic [1:0] MODE_ONESHOT = 2'd0;
  localparam logic [1:0] MODE_REPEAT  = 2'd1;

  // Per-timer request from the bus decoder
  typedef struct packed {
    logic                  wr_ctrl;
    logic                  wr_clk;
    logic                  wr_cmp;
    logic                  tick;
    logic                  fast;
    logic                  slow;
    logic [1:0]            rd_off;
    logic [DATA_WIDTH-1:0] data;
  } timer_cmd_t;

endpackage
`default_nettype wire

// ===== src/multi_channel_compare_timer.sv =====
// Top level of the compare timer bank: request register, decode, globals, result register.
//
// Usage: each request on the input channel is a bus read, a bus write or a
// clock tick (fast/slow source strobes). Every request yields exactly one
// result: read data (zero unless a read), the interrupt line and the
// pending flags as they stand after the request.
// Both channels use valid/ready. A request is taken into an input register,
// executed against the timer state once the output register is free, and its
// result lands in an output register. Throughput is one request per cycle
// while the receiver does not stall; the limit is the single update of the
// timer state per request. When the receiver stalls, the result is held, the
// request in the input register waits and in_ready_o drops once both are
// occupied; nothing is lost.
// Reset clears every timer (disabled, oneshot, fast source, divide by one,
// count and compare zero), the interrupt enables and the pending flags, and
// empties both registers.
`default_nettype none
module multi_channel_compare_timer (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [1:0]                        mode_i,
  input  wire logic [mct_pkg::ADDR_WIDTH-1:0]    addr_i,
  input  wire logic [mct_pkg::DATA_WIDTH-1:0]    write_data_i,
  input  wire logic                              fast_tick_i,
  input  wire logic                              slow_tick_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [mct_pkg::DATA_WIDTH-1:0]         read_data_o,
  output logic                                   irq_line_o,
  output logic [mct_pkg::NUM_TIMERS-1:0]         pending_mask_o
);
  import mct_pkg::*;

  // Input register
  logic                  in_valid_q;
  logic [1:0]            kind_q;
  logic [ADDR_WIDTH-1:0] addr_q;
  logic [DATA_WIDTH-1:0] wdata_q;
  logic                  fast_q, slow_q;

  // Global registers
  logic [NUM_TIMERS-1:0] ien_q, ien_d;
  logic [NUM_TIMERS-1:0] pend_q, pend_d;

  // Decode
  logic                  exec;
  logic                  aligned;
  logic [BLK_WIDTH-1:0]  blk;
  logic [1:0]            off;
  logic                  is_read, is_write, is_tick;
  logic                  glb_sel;
  logic [NUM_TIMERS-1:0] tmr_sel;
  logic [NUM_TIMERS-1:0] hits;
  logic [DATA_WIDTH-1:0] tmr_rdata [NUM_TIMERS];
  logic [DATA_WIDTH-1:0] rdata;
  timer_cmd_t            cmd [NUM_TIMERS];

  assign exec       = in_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !in_valid_q || exec;

  assign aligned  = (addr_q[1:0] == 2'b00);
  assign blk      = addr_q[7:4];
  assign off      = addr_q[3:2];
  assign is_read  = (kind_q == KIND_READ);
  assign is_write = (kind_q == KIND_WRITE);
  assign is_tick  = (kind_q == KIND_TICK);
  assign glb_sel  = aligned && (blk == '0);

  // Build per-timer requests
  for (genvar n = 0; n < NUM_TIMERS; n++) begin : g_timer
    localparam logic [BLK_WIDTH-1:0] Blk = BLK_WIDTH'(n + 1);

    assign tmr_sel[n]     = aligned && (blk == Blk);
    assign cmd[n].wr_ctrl = is_write && tmr_sel[n] && (off == OFF_CTRL);
    assign cmd[n].wr_clk  = is_write && tmr_sel[n] && (off == OFF_CLK);
    assign cmd[n].wr_cmp  = is_write && tmr_sel[n] && (off == OFF_CMP);
    assign cmd[n].tick    = is_tick;
    assign cmd[n].fast    = fast_q;
    assign cmd[n].slow    = slow_q;
    assign cmd[n].rd_off  = off;
    assign cmd[n].data    = wdata_q;

    mct_timer u_timer (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (exec),
      .cmd_i   (cmd[n]),
      .hit_o   (hits[n]),
      .rdata_o (tmr_rdata[n])
    );
  end

  // Global register updates
  always_comb begin
    ien_d  = ien_q;
    pend_d = pend_q | hits;
    if (is_write && glb_sel) begin
      if (off == OFF_IRQ_EN) begin
        ien_d = wdata_q[NUM_TIMERS-1:0];
      end else if (off == OFF_PENDING) begin
        pend_d = pend_q & ~wdata_q[NUM_TIMERS-1:0];
      end
    end
  end

  // Read mux
  always_comb begin
    rdata = '0;
    if (is_read) begin
      if (glb_sel) begin
        if (off == OFF_IRQ_EN) begin
          rdata = DATA_WIDTH'(ien_q);
        end else if (off == OFF_PENDING) begin
          rdata = DATA_WIDTH'(pend_q);
        end
      end
      for (int n = 0; n < NUM_TIMERS; n++) begin
        if (tmr_sel[n]) begin
          rdata = rdata | tmr_rdata[n];
        end
      end
    end
  end

  // Control: input and output valid flags, globals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_o <= 1'b0;
      ien_q       <= '0;
      pend_q      <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (exec) begin
        out_valid_o <= 1'b1;
        ien_q       <= ien_d;
        pend_q      <= pend_d;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // Capture request payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      kind_q  <= mode_i;
      addr_q  <= addr_i;
      wdata_q <= write_data_i;
      fast_q  <= fast_tick_i;
      slow_q  <= slow_tick_i;
    end
  end

  // Capture result payload
  always_ff @(posedge clk_i) begin
    if (exec) begin
      read_data_o    <= rdata;
      irq_line_o     <= |(pend_d & ien_d);
      pending_mask_o <= pend_d;
    end
  end

  // Result flags agree with the live global state while shown
  a_pending_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pending_mask_o == pend_q))
    else $error("pending_mask_o differs from pending state");

  a_irq_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (irq_line_o == |(pend_q & ien_q)))
    else $error("irq_line_o differs from pending and enable state");

  // Non-read requests return zero data
  a_rdata_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec && !is_read) |=> (read_data_o == '0))
    else $error("read_data_o nonzero for a non-read request");

  // A request waiting for the output register is kept
  a_hold_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !exec) |=> in_valid_q)
    else $error("waiting request dropped");

endmodule
`default_nettype wire

// ===== src/mct_timer.sv =====
// One compare timer: prescaler, counter, compare and its control registers.
`default_nettype none
module mct_timer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_i,
  input  wire mct_pkg::timer_cmd_t           cmd_i,
  output logic                               hit_o,
  output logic [mct_pkg::DATA_WIDTH-1:0]     rdata_o
);
  import mct_pkg::*;

  logic [COUNT_WIDTH-1:0] count_q, count_d, count_inc;
  logic [COUNT_WIDTH-1:0] cmp_q, cmp_d;
  logic [DIV_WIDTH-1:0]   presc_q, presc_d;
  logic [DIV_WIDTH-1:0]   div_q, div_d;
  logic [1:0]             mode_q, mode_d;
  logic                   run_q, run_d;
  logic                   src_q, src_d;
  logic                   src_edge;

  assign src_edge  = src_q ? cmd_i.slow : cmd_i.fast;
  assign count_inc = count_q + COUNT_WIDTH'(1);

  // Next state for one request
  always_comb begin
    count_d = count_q;
    cmp_d   = cmp_q;
    presc_d = presc_q;
    div_d   = div_q;
    mode_d  = mode_q;
    run_d   = run_q;
    src_d   = src_q;
    hit_o   = 1'b0;
    if (cmd_i.tick && run_q && src_edge) begin
      if (presc_q >= div_q) begin
        presc_d = '0;
        count_d = count_inc;
        if (count_inc == cmp_q) begin
          hit_o = 1'b1;
          if (mode_q == MODE_REPEAT) begin
            count_d = '0;
          end else if (mode_q == MODE_ONESHOT) begin
            run_d = 1'b0;
          end
        end
      end else begin
        presc_d = presc_q + DIV_WIDTH'(1);
      end
    end
    if (cmd_i.wr_ctrl) begin
      run_d  = cmd_i.data[0];
      mode_d = cmd_i.data[5:4];
      if (cmd_i.data[1]) begin
        count_d = '0;
        presc_d = '0;
      end
    end
    if (cmd_i.wr_clk) begin
      src_d = cmd_i.data[4];
      div_d = cmd_i.data[DIV_WIDTH-1:0];
    end
    if (cmd_i.wr_cmp) begin
      cmp_d = cmd_i.data[COUNT_WIDTH-1:0];
    end
  end

  // Register read view
  always_comb begin
    rdata_o = '0;
    case (cmd_i.rd_off)
      OFF_CTRL: begin
        rdata_o[0]   = run_q;
        rdata_o[5:4] = mode_q;
      end
      OFF_CLK: begin
        rdata_o[4]             = src_q;
        rdata_o[DIV_WIDTH-1:0] = div_q;
      end
      OFF_COUNT: rdata_o = DATA_WIDTH'(count_q);
      OFF_CMP:   rdata_o = DATA_WIDTH'(cmp_q);
      default:   rdata_o = '0;
    endcase
  end

  // Commit state when the item executes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cmp_q   <= '0;
      presc_q <= '0;
      div_q   <= '0;
      mode_q  <= MODE_ONESHOT;
      run_q   <= 1'b0;
      src_q   <= 1'b0;
    end else if (step_i) begin
      count_q <= count_d;
      cmp_q   <= cmp_d;
      presc_q <= presc_d;
      div_q   <= div_d;
      mode_q  <= mode_d;
      run_q   <= run_d;
      src_q   <= src_d;
    end
  end

endmodule
`default_nettype wire

// ===== bench/timer_bank_check_pkg.sv =====
// Scoreboard class that predicts and checks the results of the compare timer bank.
package timer_bank_check_pkg;
  import mct_pkg::*;

  // Item kind with no effect on the timers
  localparam logic [1:0] KIND_NONE = 2'd3;

  class timer_bank_scoreboard;
    typedef struct packed {
      logic [DATA_WIDTH-1:0] read_data;
      logic                  irq_line;
      logic [NUM_TIMERS-1:0] pending_mask;
    } timer_result_t;

    // Shadow copy of the timer bank
    logic [COUNT_WIDTH-1:0] count_q   [NUM_TIMERS];
    logic [COUNT_WIDTH-1:0] cmp_q     [NUM_TIMERS];
    logic                   run_q     [NUM_TIMERS];
    logic [1:0]             op_mode_q [NUM_TIMERS];
    logic                   src_q     [NUM_TIMERS];
    logic [DIV_WIDTH-1:0]   div_q     [NUM_TIMERS];
    logic [DIV_WIDTH-1:0]   presc_q   [NUM_TIMERS];
    logic [NUM_TIMERS-1:0]  irq_en_q;
    logic [NUM_TIMERS-1:0]  pending_q;

    timer_result_t due_results[$];
    int unsigned   mismatches;

    function new();
      for (int t = 0; t < NUM_TIMERS; t++) begin
        count_q[t]   = '0;
        cmp_q[t]     = '0;
        run_q[t]     = 1'b0;
        op_mode_q[t] = MODE_ONESHOT;
        src_q[t]     = 1'b0;
        div_q[t]     = '0;
        presc_q[t]   = '0;
      end
      irq_en_q   = '0;
      pending_q  = '0;
      mismatches = 0;
    endfunction

    // Return the register value seen by a bus read
    function logic [DATA_WIDTH-1:0] read_reg(logic [ADDR_WIDTH-1:0] addr);
      logic [BLK_WIDTH-1:0] blk;
      logic [1:0]           off;
      int                   t;
      blk = addr[7:4];
      off = addr[3:2];
      if (addr[1:0] != 2'b00) return '0;
      if (blk == 0) begin
        if (off == OFF_IRQ_EN) return DATA_WIDTH'(irq_en_q);
        if (off == OFF_PENDING) return DATA_WIDTH'(pending_q);
        return '0;
      end
      if (blk > NUM_TIMERS) return '0;
      t = int'(blk) - 1;
      case (off)
        OFF_CTRL:  return DATA_WIDTH'(run_q[t]) | (DATA_WIDTH'(op_mode_q[t]) << 4);
        OFF_CLK:   return (DATA_WIDTH'(src_q[t]) << 4) | DATA_WIDTH'(div_q[t]);
        OFF_COUNT: return DATA_WIDTH'(count_q[t]);
        default:   return DATA_WIDTH'(cmp_q[t]);
      endcase
    endfunction

    // Apply a bus write to the shadow registers
    function void write_reg(logic [ADDR_WIDTH-1:0] addr, logic [DATA_WIDTH-1:0] data);
      logic [BLK_WIDTH-1:0] blk;
      logic [1:0]           off;
      int                   t;
      blk = addr[7:4];
      off = addr[3:2];
      if (addr[1:0] != 2'b00 || blk > NUM_TIMERS) return;
      if (blk == 0) begin
        if (off == OFF_IRQ_EN) irq_en_q = data[NUM_TIMERS-1:0];
        else if (off == OFF_PENDING) pending_q &= ~data[NUM_TIMERS-1:0];
        return;
      end
      t = int'(blk) - 1;
      case (off)
        OFF_CTRL: begin
          run_q[t]     = data[0];
          op_mode_q[t] = data[5:4];
          // clear bit zeroes count and prescaler, never stored
          if (data[1]) begin
            count_q[t] = '0;
            presc_q[t] = '0;
          end
        end
        OFF_CLK: begin
          src_q[t] = data[4];
          div_q[t] = data[DIV_WIDTH-1:0];
        end
        OFF_CMP: cmp_q[t] = data[COUNT_WIDTH-1:0];
        default: ;
      endcase
    endfunction

    // Advance every running timer whose source strobes
    function void advance(logic fast, logic slow);
      logic strobe;
      for (int t = 0; t < NUM_TIMERS; t++) begin
        strobe = src_q[t] ? slow : fast;
        if (!run_q[t] || !strobe) continue;
        if (presc_q[t] >= div_q[t]) begin
          presc_q[t] = '0;
          count_q[t] = count_q[t] + 1'b1;
          if (count_q[t] == cmp_q[t]) begin
            pending_q[t] = 1'b1;
            if (op_mode_q[t] == MODE_REPEAT) count_q[t] = '0;
            else if (op_mode_q[t] == MODE_ONESHOT) run_q[t] = 1'b0;
          end
        end else begin
          presc_q[t] = presc_q[t] + 1'b1;
        end
      end
    endfunction

    // Note an accepted request and queue the result it must produce
    function void take_request(logic [1:0] kind, logic [ADDR_WIDTH-1:0] addr,
                               logic [DATA_WIDTH-1:0] data, logic fast, logic slow);
      timer_result_t res;
      res.read_data = '0;
      case (kind)
        KIND_READ:  res.read_data = read_reg(addr);
        KIND_WRITE: write_reg(addr, data);
        KIND_TICK:  advance(fast, slow);
        default:    ;
      endcase
      res.irq_line     = |(pending_q & irq_en_q);
      res.pending_mask = pending_q;
      due_results.push_back(res);
    endfunction

    // Compare an accepted result with the oldest queued one
    function void match_result(logic [DATA_WIDTH-1:0] read_data, logic irq_line,
                               logic [NUM_TIMERS-1:0] pending_mask);
      timer_result_t want;
      if (due_results.size() == 0) begin
        $error("unexpected result: read_data=%h irq_line=%b pending_mask=%b",
               read_data, irq_line, pending_mask);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      if (read_data !== want.read_data) begin
        $error("read_data: expected %h, got %h", want.read_data, read_data);
        mismatches++;
      end
      if (irq_line !== want.irq_line) begin
        $error("irq_line: expected %b, got %b", want.irq_line, irq_line);
        mismatches++;
      end
      if (pending_mask !== want.pending_mask) begin
        $error("pending_mask: expected %b, got %b", want.pending_mask, pending_mask);
        mismatches++;
      end
    endfunction
  endclass

endpackage

// ===== bench/tb.sv =====
// Testbench top for the compare timer bank: clock, reset, request driver and checks.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mct_pkg::*;
  import timer_bank_check_pkg::*;

  localparam int unsigned RANDOM_PER_PHASE = 235;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_ready_o;
  logic [1:0]            mode_i       = KIND_READ;
  logic [ADDR_WIDTH-1:0] addr_i       = '0;
  logic [DATA_WIDTH-1:0] write_data_i = '0;
  logic                  fast_tick_i  = 1'b0;
  logic                  slow_tick_i  = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i  = 1'b0;
  logic [DATA_WIDTH-1:0] read_data_o;
  logic                  irq_line_o;
  logic [NUM_TIMERS-1:0] pending_mask_o;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  timer_bank_scoreboard timer_sb = new();

  multi_channel_compare_timer DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .mode_i, .addr_i, .write_data_i,
    .fast_tick_i, .slow_tick_i, .out_valid_o, .out_ready_i, .read_data_o,
    .irq_line_o, .pending_mask_o
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Stall the receiver at random
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Note each accepted request
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      timer_sb.take_request(mode_i, addr_i, write_data_i, fast_tick_i, slow_tick_i);
  end

  // Check each accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      timer_sb.match_result(read_data_o, irq_line_o, pending_mask_o);
  end

  function automatic logic [ADDR_WIDTH-1:0] reg_addr(logic [3:0] blk, logic [1:0] off);
    return {blk, off, 2'b00};
  endfunction

  // Offer one request and hold it until accepted
  task automatic send_request(logic [1:0] kind, logic [ADDR_WIDTH-1:0] addr,
                              logic [DATA_WIDTH-1:0] data, logic fast, logic slow);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= kind;
    addr_i       <= addr;
    write_data_i <= data;
    fast_tick_i  <= fast;
    slow_tick_i  <= slow;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic bus_write(logic [ADDR_WIDTH-1:0] addr, logic [DATA_WIDTH-1:0] data);
    send_request(KIND_WRITE, addr, data, 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  task automatic bus_read(logic [ADDR_WIDTH-1:0] addr);
    send_request(KIND_READ, addr, $urandom(), 1'($urandom_range(1)),
                 1'($urandom_range(1)));
  endtask

  task automatic clock_tick(logic fast, logic slow);
    send_request(KIND_TICK, 8'($urandom()), $urandom(), fast, slow);
  endtask

  // Register-level checks of every special case
  task automatic run_directed();
    bus_read(reg_addr(0, OFF_IRQ_EN));
    bus_write(reg_addr(1, OFF_CMP), 32'd3);
    bus_write(reg_addr(1, OFF_CLK), 32'h0);
    bus_write(reg_addr(0, OFF_IRQ_EN), 32'hFFFF_FFFF);
    // oneshot with clear: stops after three fast ticks
    bus_write(reg_addr(1, OFF_CTRL), 32'h0000_0003);
    repeat (3) clock_tick(1'b1, 1'b0);
    bus_read(reg_addr(1, OFF_COUNT));
    bus_read(reg_addr(0, OFF_PENDING));
    bus_write(reg_addr(0, OFF_PENDING), 32'hFFFF_FFFF);
    // repeat on slow source; lower the divide code under the prescaler
    bus_write(reg_addr(6, OFF_CLK), 32'h12);
    bus_write(reg_addr(6, OFF_CMP), 32'd1);
    bus_write(reg_addr(6, OFF_CTRL), 32'h11);
    clock_tick(1'b1, 1'b1);
    clock_tick(1'b0, 1'b1);
    bus_write(reg_addr(6, OFF_CLK), 32'h10);
    clock_tick(1'b0, 1'b1);
    bus_read(reg_addr(6, OFF_CLK));
    // freerun with all data bits set; count register ignores writes
    bus_write(reg_addr(2, OFF_CTRL), 32'hFFFF_FFFF);
    clock_tick(1'b1, 1'b0);
    bus_write(reg_addr(2, OFF_COUNT), 32'hFFFF_FFFF);
    bus_read(reg_addr(2, OFF_COUNT));
    bus_read(reg_addr(2, OFF_CTRL));
    // unaligned, unmapped and reserved global offsets
    bus_write(8'h0D, 32'hFFFF_FFFF);
    bus_read(8'hFF);
    bus_write(8'h7C, 32'hFFFF_FFFF);
    bus_read(8'h70);
    bus_read(8'h04);
    bus_read(8'h0C);
    send_request(KIND_NONE, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
  endtask

  // Mostly well-formed timer traffic, some noise
  task automatic random_request();
    int unsigned           pick;
    logic [3:0]            blk;
    logic [1:0]            off;
    logic [DATA_WIDTH-1:0] data;
    pick = $urandom_range(99);
    blk  = 4'($urandom_range(1, NUM_TIMERS));
    off  = 2'($urandom_range(3));
    data = $urandom();
    if (pick < 45) begin
      clock_tick($urandom_range(3) != 0, 1'($urandom_range(1)));
    end else if (pick < 65) begin
      case (off)
        OFF_CTRL: begin
          data[0] = ($urandom_range(3) != 0);
          data[1] = ($urandom_range(3) == 0);
        end
        OFF_CLK:  if ($urandom_range(3) != 0) data[3:0] = 4'($urandom_range(2));
        OFF_CMP:  if ($urandom_range(9) != 0) data = $urandom_range(1, 24);
        default:  ;
      endcase
      bus_write(reg_addr(blk, off), data);
    end else if (pick < 72) begin
      bus_write(reg_addr(0, $urandom_range(1) ? OFF_IRQ_EN : OFF_PENDING), data);
    end else if (pick < 90) begin
      bus_read(reg_addr(4'($urandom_range(NUM_TIMERS)), off));
    end else begin
      send_request(2'($urandom_range(3)), 8'($urandom()), data,
                   1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    send_idle_pct = 11;
    recv_idle_pct = 86;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    repeat (RANDOM_PER_PHASE) random_request();
    send_idle_pct = 86;
    recv_idle_pct = 11;
    repeat (RANDOM_PER_PHASE) random_request();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (RANDOM_PER_PHASE) random_request();
    in_valid_i <= 1'b0;
    // drain outstanding results, then let the pipeline settle
    while (timer_sb.due_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (timer_sb.mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end
endmodule
